// File: src/zsrd_pkg.sv
// Package for the zero-suppressed row decoder.
// Holds the transaction structs, the phase enum and the fixed widths and codes.
// No dependencies.
package zsrd_pkg;

  localparam int unsigned TIME_BITS   = 16;
  localparam int unsigned SEQ_DEPTH   = 256;
  localparam int unsigned SEQ_IDX_W   = $clog2(SEQ_DEPTH);
  localparam int unsigned ACC_W       = 20;
  localparam int unsigned HELD_W      = 5;
  localparam int unsigned HDR_IDX_W   = 9;
  localparam int unsigned PADDR_W     = 2;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [PADDR_W-1:0] REG_TWELVE_BIT_ADDR = 2'd0;

  localparam logic [HELD_W-1:0] SAMPLE_BITS_NARROW = 5'd10;
  localparam logic [HELD_W-1:0] SAMPLE_BITS_WIDE   = 5'd12;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic                 row_start;
    logic [TIME_BITS-1:0] time_bin;
    logic [7:0]           row_number;
  } in_item_t;

  typedef struct packed {
    logic [11:0]          adc_value;
    logic [8:0]           pad_number;
    logic [TIME_BITS-1:0] sample_time_bin;
    logic [7:0]           sample_row;
    logic                 last_of_row;
    logic                 format_error;
  } out_item_t;

  // One entry of the table of non-empty sequences built during the header.
  typedef struct packed {
    logic [7:0] start_pad;
    logic [7:0] length;
  } seq_entry_t;

endpackage

// File: src/zero_suppressed_row_decoder.sv
// Top level of the zero-suppressed row decoder.
// Depends on zsrd_pkg for the transaction structs, the phase enum and constants.
// Contains the decoder, its sequence table memory and the output skid stage.
//
// Usage: the input channel takes one byte of a detector row per transaction.
// A byte flagged row_start carries the sequence count and samples the row's
// time bin and row number. Pairs of start pad and running end count follow,
// then the 10- or 12-bit ADC samples packed LSB first. Each completed sample
// leaves on the output channel with its pad, time bin and row; the final
// sample of the row is flagged and any padding bits after it are dropped.
// A row start arriving before the row has finished produces one result with
// format_error set, then starts the new row.
// A result is registered in the result register, or in the skid register
// if the receiver stalls. Throughput: one byte per cycle while skid is empty.
// The header is compacted into a 256-entry table of non-empty sequences with
// one write port and one registered read port; the entry after the current
// one is always prefetched, so moving between sequences never stalls input.
// When the receiver stalls, the result register holds and a one-entry skid
// register takes one more result; only while the skid is full is the input
// stalled. Reset empties both and returns the decoder to waiting for a row
// start; the 10-bit packing is selected after reset.
module zero_suppressed_row_decoder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Byte input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  zsrd_pkg::in_item_t                    in_data_i,
  // Sample output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output zsrd_pkg::out_item_t                   out_data_o,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [zsrd_pkg::PADDR_W-1:0]          paddr,
  input  logic [zsrd_pkg::PDATA_W-1:0]          pwdata,
  output logic [zsrd_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);

  // Configuration
  logic twelve_q;
  logic cfg_we;

  // Decoder state
  zsrd_pkg::phase_e                     phase_q, phase_d;
  logic [7:0]                           seq_count_q, seq_count_d;
  logic [zsrd_pkg::HDR_IDX_W-1:0]       hdr_idx_q, hdr_idx_d;
  logic [7:0]                           start_hold_q, start_hold_d;
  logic [7:0]                           prev_end_q, prev_end_d;
  logic [zsrd_pkg::SEQ_IDX_W-1:0]       wr_cnt_q, wr_cnt_d;
  logic [zsrd_pkg::SEQ_IDX_W-1:0]       rd_idx_q, rd_idx_d;
  zsrd_pkg::seq_entry_t                 cur_q, cur_d;
  logic [zsrd_pkg::ACC_W-1:0]           acc_q, acc_d;
  logic [zsrd_pkg::HELD_W-1:0]          held_q, held_d;
  logic [7:0]                           offset_q, offset_d;
  logic [7:0]                           emitted_q, emitted_d;
  logic [7:0]                           total_q, total_d;
  logic [zsrd_pkg::TIME_BITS-1:0]       tbin_q, tbin_d;
  logic [7:0]                           row_q, row_d;

  // Sequence table
  zsrd_pkg::seq_entry_t                 seq_mem [zsrd_pkg::SEQ_DEPTH];
  zsrd_pkg::seq_entry_t                 rdata_q;
  zsrd_pkg::seq_entry_t                 wr_entry;
  logic                                 mem_we;

  // Result of the accepted byte
  logic                                 in_fire;
  logic                                 res_valid;
  zsrd_pkg::out_item_t                  res;

  // Output register and skid
  logic                                 out_valid_q;
  zsrd_pkg::out_item_t                  out_q;
  logic                                 skid_valid_q;
  zsrd_pkg::out_item_t                  skid_q;
  logic                                 out_take;

  // Datapath temporaries
  logic [zsrd_pkg::HELD_W-1:0]          sample_bits;
  logic [zsrd_pkg::ACC_W-1:0]           acc_new;
  logic [zsrd_pkg::HELD_W-1:0]          held_new;
  logic [7:0]                           seq_len;
  logic [7:0]                           offset_nxt;
  logic [7:0]                           emitted_nxt;
  logic [zsrd_pkg::HDR_IDX_W-1:0]       hdr_idx_nxt;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr == zsrd_pkg::REG_TWELVE_BIT_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twelve_q <= 1'b0;
    end else if (cfg_we) begin
      twelve_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == zsrd_pkg::REG_TWELVE_BIT_ADDR) begin
      prdata[0] = twelve_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder
  // ---------------------------------------------------------------------------
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;

  assign sample_bits = twelve_q ? zsrd_pkg::SAMPLE_BITS_WIDE : zsrd_pkg::SAMPLE_BITS_NARROW;
  assign acc_new     = acc_q | ({{(zsrd_pkg::ACC_W-8){1'b0}}, in_data_i.data_byte} << held_q);
  assign held_new    = held_q + 5'd8;
  assign seq_len     = (in_data_i.data_byte > prev_end_q) ?
                       (in_data_i.data_byte - prev_end_q) : 8'd0;
  assign offset_nxt  = offset_q + 8'd1;
  assign emitted_nxt = emitted_q + 8'd1;
  assign hdr_idx_nxt = hdr_idx_q + 9'd1;

  always_comb begin
    phase_d      = phase_q;
    seq_count_d  = seq_count_q;
    hdr_idx_d    = hdr_idx_q;
    start_hold_d = start_hold_q;
    prev_end_d   = prev_end_q;
    wr_cnt_d     = wr_cnt_q;
    rd_idx_d     = rd_idx_q;
    cur_d        = cur_q;
    acc_d        = acc_q;
    held_d       = held_q;
    offset_d     = offset_q;
    emitted_d    = emitted_q;
    total_d      = total_q;
    tbin_d       = tbin_q;
    row_d        = row_q;
    mem_we       = 1'b0;
    wr_entry     = '{start_pad: start_hold_q, length: seq_len};
    res_valid    = 1'b0;
    res          = '{adc_value:       '0,
                     pad_number:      '0,
                     sample_time_bin: tbin_q,
                     sample_row:      row_q,
                     last_of_row:     1'b0,
                     format_error:    1'b0};

    if (in_fire) begin
      if (in_data_i.row_start) begin
        // A row that has not finished is abandoned and reported.
        if (phase_q != zsrd_pkg::PH_IDLE) begin
          res_valid        = 1'b1;
          res.format_error = 1'b1;
        end
        tbin_d      = in_data_i.time_bin;
        row_d       = in_data_i.row_number;
        seq_count_d = in_data_i.data_byte;
        hdr_idx_d   = '0;
        wr_cnt_d    = '0;
        prev_end_d  = '0;
        offset_d    = '0;
        emitted_d   = '0;
        acc_d       = '0;
        held_d      = '0;
        phase_d     = (in_data_i.data_byte != 8'd0) ? zsrd_pkg::PH_HEADER
                                                     : zsrd_pkg::PH_IDLE;
      end else begin
        case (phase_q)
          zsrd_pkg::PH_HEADER: begin
            hdr_idx_d = hdr_idx_nxt;
            if (!hdr_idx_q[0]) begin
              start_hold_d = in_data_i.data_byte;
            end else begin
              // Only non-empty sequences enter the table, so the data phase
              // never has to skip over empty ones.
              prev_end_d = in_data_i.data_byte;
              if (seq_len != 8'd0) begin
                mem_we   = 1'b1;
                wr_cnt_d = wr_cnt_q + 8'd1;
                if (wr_cnt_q == '0) begin
                  cur_d = wr_entry;
                end
              end
            end
            if (hdr_idx_nxt >= {seq_count_q, 1'b0}) begin
              total_d   = in_data_i.data_byte;
              offset_d  = '0;
              emitted_d = '0;
              rd_idx_d  = 8'd1;
              phase_d   = (in_data_i.data_byte != 8'd0) ? zsrd_pkg::PH_DATA
                                                         : zsrd_pkg::PH_IDLE;
            end
          end
          zsrd_pkg::PH_DATA: begin
            acc_d  = acc_new;
            held_d = held_new;
            if (held_new >= sample_bits) begin
              res_valid = 1'b1;
              if (twelve_q) begin
                res.adc_value = acc_new[11:0];
                acc_d         = acc_new >> 12;
              end else begin
                res.adc_value = {2'b00, acc_new[9:0]};
                acc_d         = acc_new >> 10;
              end
              held_d          = held_new - sample_bits;
              res.pad_number  = {1'b0, cur_q.start_pad} + {1'b0, offset_q};
              res.last_of_row = (emitted_nxt >= total_q);
              emitted_d       = emitted_nxt;
              offset_d        = offset_nxt;
              if (emitted_nxt >= total_q) begin
                phase_d = zsrd_pkg::PH_IDLE;
                acc_d   = '0;
                held_d  = '0;
              end else if (offset_nxt == cur_q.length) begin
                // Move on to the prefetched entry and fetch the one after it.
                cur_d    = rdata_q;
                offset_d = '0;
                rd_idx_d = rd_idx_q + 8'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= zsrd_pkg::PH_IDLE;
      seq_count_q  <= '0;
      hdr_idx_q    <= '0;
      start_hold_q <= '0;
      prev_end_q   <= '0;
      wr_cnt_q     <= '0;
      rd_idx_q     <= '0;
      cur_q        <= '0;
      acc_q        <= '0;
      held_q       <= '0;
      offset_q     <= '0;
      emitted_q    <= '0;
      total_q      <= '0;
      tbin_q       <= '0;
      row_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      seq_count_q  <= seq_count_d;
      hdr_idx_q    <= hdr_idx_d;
      start_hold_q <= start_hold_d;
      prev_end_q   <= prev_end_d;
      wr_cnt_q     <= wr_cnt_d;
      rd_idx_q     <= rd_idx_d;
      cur_q        <= cur_d;
      acc_q        <= acc_d;
      held_q       <= held_d;
      offset_q     <= offset_d;
      emitted_q    <= emitted_d;
      total_q      <= total_d;
      tbin_q       <= tbin_d;
      row_q        <= row_d;
    end
  end

  // The read port follows the next read index every cycle, so the entry after
  // the current one is always waiting in rdata_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seq_mem[wr_cnt_q] <= wr_entry;
    end
    rdata_q <= seq_mem[rd_idx_d];
  end

  // ---------------------------------------------------------------------------
  // Output register and skid stage
  // ---------------------------------------------------------------------------
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= in_fire && res_valid;
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while result register empty");

  a_idle_no_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == zsrd_pkg::PH_IDLE) |-> (held_q == '0))
    else $error("bits held while waiting for a row start");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q < zsrd_pkg::SAMPLE_BITS_WIDE)
    else $error("a complete sample was left in the accumulator");

  a_data_seq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == zsrd_pkg::PH_DATA) |-> (cur_q.length != 8'd0))
    else $error("data phase on an empty sequence entry");

  a_error_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.format_error) |->
      (!out_data_o.last_of_row && (out_data_o.adc_value == '0)))
    else $error("format error result carries sample data");
`endif

endmodule
